>>> rtl/core/rfbfp_pkg.sv
// Shared types, byte codes and status codes for the RF bridge frame parser.
`timescale 1ns / 1ps
`default_nettype none

package rfbfp_pkg;

  // Default length of a learn / key frame, start and end bytes included
  localparam int LONG_FRAME_BYTES_DFLT = 12;

  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd10000;

  // Frame marker and type bytes
  localparam logic [7:0] BYTE_START   = 8'hAA;
  localparam logic [7:0] BYTE_ACK     = 8'hA0;
  localparam logic [7:0] BYTE_TMO_RPT = 8'hA2;
  localparam logic [7:0] BYTE_LEARNED = 8'hA3;
  localparam logic [7:0] BYTE_KEY     = 8'hA4;
  localparam logic [7:0] BYTE_END     = 8'h55;

  localparam logic [3:0] SHORT_FRAME_LEN = 4'd3;

  // Result status codes
  localparam logic [2:0] ST_ACK        = 3'd0;
  localparam logic [2:0] ST_TMO_RPT    = 3'd1;
  localparam logic [2:0] ST_LEARNED    = 3'd2;
  localparam logic [2:0] ST_KEY        = 3'd3;
  localparam logic [2:0] ST_BAD_TYPE   = 3'd4;
  localparam logic [2:0] ST_BAD_END    = 3'd5;
  localparam logic [2:0] ST_RX_TIMEOUT = 3'd6;

  // Payload bytes kept: frame bytes 2 through 10
  localparam logic [3:0] FB_FIRST = 4'd2;
  localparam logic [3:0] FB_LAST  = 4'd10;
  localparam int         FB_DEPTH = 9;
  localparam int         FB_IDX_W = $clog2(FB_DEPTH);

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_TYPE  = 6'b000010,
    PH_ACK   = 6'b000100,
    PH_TMO   = 6'b001000,
    PH_LEARN = 6'b010000,
    PH_KEY   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] sync_time;
    logic [15:0] low_time;
    logic [15:0] high_time;
    logic [23:0] key_code;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/rfbfp_in_reg.sv
// Input register stage: captures one beat and stalls the channel when it cannot move on.
`timescale 1ns / 1ps
`default_nettype none

module rfbfp_in_reg
  import rfbfp_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire item_t in_item,
  input  wire        adv,
  output logic       item_valid,
  output item_t      item
);

  logic  valid_r;
  item_t item_r;

  // Stall only while a held beat cannot advance
  assign in_stall   = valid_r && !adv;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/rfbfp_parser.sv
// Frame parser state, payload byte store and result decode.
`timescale 1ns / 1ps
`default_nettype none

module rfbfp_parser
  import rfbfp_pkg::*;
#(
  parameter int LONG_FRAME_BYTES = LONG_FRAME_BYTES_DFLT
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire  [15:0] cfg_data,
  input  wire         item_valid,
  input  wire  item_t item,
  input  wire         out_free,
  output logic        adv,
  output logic        res_valid,
  output result_t     res
);

  localparam logic [3:0] LONG_LEN = 4'(LONG_FRAME_BYTES);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [3:0]  len_r, len_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic [15:0] timeout_r;
  logic [7:0]  fb_r [FB_DEPTH];

  logic                wr_en;
  logic [3:0]          cnt_inc;
  logic [3:0]          wr_off;
  logic [FB_IDX_W-1:0] wr_idx;
  logic                timed_out;

  assign timed_out = elapsed_r >= timeout_r;
  assign cnt_inc   = cnt_r + 4'd1;
  assign wr_off    = cnt_r - FB_FIRST;
  assign wr_idx    = wr_off[FB_IDX_W-1:0];

  // Items without a result always advance; a result needs a free output slot
  assign adv = item_valid && (!res_valid || out_free);

  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    len_nxt     = len_r;
    elapsed_nxt = elapsed_r;
    wr_en       = 1'b0;
    res_valid   = 1'b0;
    res         = '0;

    if (item.mode) begin
      if (phase_r != PH_IDLE) begin
        if (timed_out) begin
          res_valid  = 1'b1;
          res.status = ST_RX_TIMEOUT;
        end else begin
          elapsed_nxt = elapsed_r + 16'd1;
        end
      end
    end else if (phase_r == PH_IDLE) begin
      if (item.rx_byte == BYTE_START) begin
        phase_nxt   = PH_TYPE;
        cnt_nxt     = 4'd1;
        len_nxt     = 4'd0;
        elapsed_nxt = 16'd0;
      end
    end else if (timed_out) begin
      // drop the byte, report the timeout instead
      res_valid  = 1'b1;
      res.status = ST_RX_TIMEOUT;
    end else if (phase_r == PH_TYPE) begin
      cnt_nxt = cnt_inc;
      unique case (item.rx_byte)
        BYTE_ACK: begin
          len_nxt   = SHORT_FRAME_LEN;
          phase_nxt = PH_ACK;
        end
        BYTE_TMO_RPT: begin
          len_nxt   = SHORT_FRAME_LEN;
          phase_nxt = PH_TMO;
        end
        BYTE_LEARNED: begin
          len_nxt   = LONG_LEN;
          phase_nxt = PH_LEARN;
        end
        BYTE_KEY: begin
          len_nxt   = LONG_LEN;
          phase_nxt = PH_KEY;
        end
        default: begin
          res_valid  = 1'b1;
          res.status = ST_BAD_TYPE;
        end
      endcase
    end else begin
      cnt_nxt = cnt_inc;
      wr_en   = (cnt_r >= FB_FIRST) && (cnt_r <= FB_LAST);
      if (cnt_inc == len_r) begin
        res_valid = 1'b1;
        if (item.rx_byte != BYTE_END) begin
          res.status = ST_BAD_END;
        end else begin
          unique case (phase_r)
            PH_ACK:   res.status = ST_ACK;
            PH_TMO:   res.status = ST_TMO_RPT;
            PH_LEARN: res.status = ST_LEARNED;
            PH_KEY:   res.status = ST_KEY;
            default:  res.status = ST_ACK;
          endcase
          if (phase_r == PH_LEARN || phase_r == PH_KEY) begin
            res.sync_time = {fb_r[0], fb_r[1]};
            res.low_time  = {fb_r[2], fb_r[3]};
            res.high_time = {fb_r[4], fb_r[5]};
            res.key_code  = {fb_r[6], fb_r[7], fb_r[8]};
          end
        end
      end
    end

    // every result returns the parser to idle
    if (res_valid) begin
      phase_nxt   = PH_IDLE;
      cnt_nxt     = 4'd0;
      len_nxt     = 4'd0;
      elapsed_nxt = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      cnt_r     <= 4'd0;
      len_r     <= 4'd0;
      elapsed_r <= 16'd0;
    end else if (adv) begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      len_r     <= len_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_TICKS_RST;
    end else if (cfg_we) begin
      timeout_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && wr_en) begin
      fb_r[wr_idx] <= item.rx_byte;
    end
  end

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> (cnt_r == 4'd0 && len_r == 4'd0 && elapsed_r == 16'd0))
    else $error("idle parser holds stale frame state");

  a_result_idles: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res_valid |=> phase_r == PH_IDLE)
    else $error("parser not idle after a result");

  a_type_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_TYPE |-> (cnt_r == 4'd1 && len_r == 4'd0))
    else $error("type phase with wrong byte count");

  a_stall_no_adv: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && res_valid && !out_free |-> !adv)
    else $error("result advanced into a full output register");

endmodule

`default_nettype wire

>>> rtl/core/rfbfp_out_reg.sv
// Result register: holds one result beat until the consumer takes it.
`timescale 1ns / 1ps
`default_nettype none

module rfbfp_out_reg
  import rfbfp_pkg::*;
(
  input  wire          clk,
  input  wire          rst_n,
  input  wire          load,
  input  wire result_t res,
  output logic         out_free,
  output logic         out_valid,
  input  wire          out_stall,
  output result_t      out_res
);

  logic    valid_r;
  result_t res_r;

  assign out_free  = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && out_stall |=> valid_r && $stable(res_r))
    else $error("stalled result beat lost or changed");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> out_free)
    else $error("result loaded over a pending beat");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> valid_r)
    else $error("loaded result not presented");

endmodule

`default_nettype wire

>>> rtl/core/rf_bridge_frame_parser.sv
// Top level of the RF bridge frame parser: input register, parser, result register.
// Path: the beat completing a result is first loaded into the input register, then its result
//   into the result register, where out_valid rises; a full, stalled result register holds it back.
// Throughput: one byte or tick beat per cycle; out_stall backs up into in_stall.
// Reset (rst_n low, synchronous): parser idle, counters cleared, timeout_ticks 10000,
//   both channels empty. Payload byte store is not reset.
`timescale 1ns / 1ps
`default_nettype none

module rf_bridge_frame_parser
  import rfbfp_pkg::*;
#(
  parameter int LONG_FRAME_BYTES = LONG_FRAME_BYTES_DFLT
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [15:0] cfg_data,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         in_mode,
  input  wire  [7:0]  in_rx_byte,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_sync_time,
  output logic [15:0] out_low_time,
  output logic [15:0] out_high_time,
  output logic [23:0] out_key_code
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    adv;
  logic    out_free;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign cfg_ready       = 1'b1;
  assign in_item.mode    = in_mode;
  assign in_item.rx_byte = in_rx_byte;

  rfbfp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .adv        (adv),
    .item_valid (item_valid),
    .item       (item)
  );

  rfbfp_parser #(
    .LONG_FRAME_BYTES (LONG_FRAME_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .adv        (adv),
    .res_valid  (res_valid),
    .res        (res)
  );

  rfbfp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv && res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_status    = out_res.status;
  assign out_sync_time = out_res.sync_time;
  assign out_low_time  = out_res.low_time;
  assign out_high_time = out_res.high_time;
  assign out_key_code  = out_res.key_code;

endmodule

`default_nettype wire
